>>> rtl/assert_macros.svh
// Assertion macros shared by the hash table RTL.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);
// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);
`endif

>>> rtl/oaht_pkg.sv
// Shared types and constants for the open-address hash table.
// No dependencies.
package oaht_pkg;
    localparam logic [2:0] OP_FIND      = 3'd0;
    localparam logic [2:0] OP_ADD       = 3'd1;
    localparam logic [2:0] OP_DELETE    = 3'd2;
    localparam logic [2:0] OP_SCAN_RST  = 3'd3;
    localparam logic [2:0] OP_SCAN_NEXT = 3'd4;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_REFUSED = 2'd1;
    localparam logic [1:0] ST_SCANEND = 2'd2;

    localparam int MARK_VALID   = 63;
    localparam int MARK_VISIBLE = 62;
    localparam logic [9:0] LOAD_LIMIT_RESET = 10'd614;

    // Controller to datapath commands
    typedef struct packed {
        logic latch_in;    // capture input item, start probe at home bucket
        logic rd_probe;    // issue read at probe index
        logic rd_scan;     // issue read at scan position
        logic step_probe;  // advance probe index by triangular step
        logic wr_new;      // write mark, key and value at probe index
        logic wr_val;      // write value only
        logic wr_tomb;     // write tombstone mark
        logic clr_sweep;   // write zero mark at sweep index, advance sweep
        logic scan_start;  // position 0, scan active
        logic scan_adv;    // position advances
        logic scan_stop;   // scan inactive
        logic live_inc;
        logic live_dec;
        logic res_load;    // load result register
        logic [1:0] res_status;
        logic res_hit;
        logic res_data;    // result key/value come from the read bucket
        logic res_vonly;   // only value comes from read bucket
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic [2:0] op;
        logic empty;       // read bucket never used
        logic match;       // read bucket matches item
        logic live;        // read bucket valid and visible
        logic probe_last;  // probe count exhausted
        logic room;        // used count below limits
        logic scan_active;
        logic scan_end;    // scan position past last bucket
        logic sweep_last;
        logic live_pos;    // live count above zero
    } t_stat;
endpackage

>>> rtl/open_address_hash_table.sv
// Top level of the open-address hash table with triangular probing.
// Depends on oaht_pkg, oaht_ctrl and oaht_datapath.
//
//  channel | direction | handshake           | payload
//  input   | in        | i_valid / o_stall   | opcode, key, key_hash, value_in
//  result  | out       | o_valid / i_stall   | hit, status, key_out, value_out, live_entries
//  config  | in        | i_cfg_valid / o_cfg_ready | load_limit
//
// Find, add and delete pass S_PRD and S_PCHK for each probed bucket, paced by the
// single registered read port; scan reset and undefined opcodes load the result from S_PRD.
// Scan next passes S_PRD, then S_SRD and S_SCHK for each bucket read, and ends in S_SRD when no bucket is left.
// After reset a clearing pass writes a zero mark to every bucket; no item is taken
// meanwhile. A held result blocks the next item, which can be taken in the cycle
// after the result is taken.
module open_address_hash_table #(
    parameter int BUCKET_COUNT = 1024,
    parameter int KEY_BITS     = 64,
    parameter int VALUE_BITS   = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [2:0]  i_opcode,
    input  logic [63:0] i_key,
    input  logic [63:0] i_key_hash,
    input  logic [63:0] i_value_in,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_hit,
    output logic [1:0]  o_status,
    output logic [63:0] o_key_out,
    output logic [63:0] o_value_out,
    output logic [10:0] o_live_entries,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [9:0]  i_cfg_data
);
    oaht_pkg::t_cmd  cmd;
    oaht_pkg::t_stat stat;
    logic [9:0]      r_load_limit;

    // Load limit register
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_load_limit <= oaht_pkg::LOAD_LIMIT_RESET;
        end else if (i_cfg_valid) begin
            r_load_limit <= i_cfg_data;
        end
    end

    oaht_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    oaht_datapath #(
        .BUCKET_COUNT (BUCKET_COUNT),
        .KEY_BITS     (KEY_BITS),
        .VALUE_BITS   (VALUE_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_opcode       (i_opcode),
        .i_key          (i_key),
        .i_key_hash     (i_key_hash),
        .i_value_in     (i_value_in),
        .i_load_limit   (r_load_limit),
        .o_hit          (o_hit),
        .o_status       (o_status),
        .o_key_out      (o_key_out),
        .o_value_out    (o_value_out),
        .o_live_entries (o_live_entries)
    );
endmodule

>>> rtl/oaht_datapath.sv
// Datapath: bucket memories, probe and scan indexes, counters, result register.
// Depends on oaht_pkg.
`include "assert_macros.svh"
module oaht_datapath #(
    parameter int BUCKET_COUNT = 1024,
    parameter int KEY_BITS     = 64,
    parameter int VALUE_BITS   = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  oaht_pkg::t_cmd    i_cmd,
    output oaht_pkg::t_stat   o_stat,
    input  logic [2:0]        i_opcode,
    input  logic [63:0]       i_key,
    input  logic [63:0]       i_key_hash,
    input  logic [63:0]       i_value_in,
    input  logic [9:0]        i_load_limit,
    output logic              o_hit,
    output logic [1:0]        o_status,
    output logic [63:0]       o_key_out,
    output logic [63:0]       o_value_out,
    output logic [10:0]       o_live_entries
);
    localparam int IW = $clog2(BUCKET_COUNT);
    localparam int KW = (KEY_BITS > 0) ? KEY_BITS : 1;
    localparam int VW = (VALUE_BITS > 0) ? VALUE_BITS : 1;

    logic [63:0]   mem_mark [BUCKET_COUNT];
    logic [KW-1:0] mem_key  [BUCKET_COUNT];
    logic [VW-1:0] mem_val  [BUCKET_COUNT];

    logic [2:0]    r_op;
    logic [KW-1:0] r_key;
    logic [63:0]   r_marked;
    logic [VW-1:0] r_val;
    logic [IW-1:0] r_idx;
    logic [IW-1:0] r_step;
    logic [IW:0]   r_count;
    logic [IW:0]   r_scan_pos;
    logic          r_scan_act;
    logic [IW-1:0] r_sweep;
    logic [10:0]   r_live;
    logic [IW:0]   r_used;
    logic [63:0]   r_rd_mark;
    logic [KW-1:0] r_rd_key;
    logic [VW-1:0] r_rd_val;

    logic [IW-1:0] n_rd_addr;
    logic [IW-1:0] wr_addr;
    logic [63:0]   wr_mark;
    logic          wr_mark_en;

    // Read address: scan position or probe index
    assign n_rd_addr = i_cmd.rd_scan ? r_scan_pos[IW-1:0] : r_idx;

    // Write port selection
    always_comb begin
        wr_addr    = r_idx;
        wr_mark    = r_marked;
        wr_mark_en = i_cmd.wr_new;
        if (i_cmd.clr_sweep) begin
            wr_addr    = r_sweep;
            wr_mark    = '0;
            wr_mark_en = 1'b1;
        end else if (i_cmd.wr_tomb) begin
            wr_mark    = 64'h8000_0000_0000_0000;
            wr_mark_en = 1'b1;
        end
    end

    // Bucket memories
    always_ff @(posedge i_clk) begin
        if (wr_mark_en) begin
            mem_mark[wr_addr] <= wr_mark;
        end
        if (i_cmd.wr_new) begin
            mem_key[wr_addr] <= r_key;
        end
        if (i_cmd.wr_new || i_cmd.wr_val) begin
            mem_val[wr_addr] <= r_val;
        end
        if (i_cmd.rd_probe || i_cmd.rd_scan) begin
            r_rd_mark <= mem_mark[n_rd_addr];
            r_rd_key  <= mem_key[n_rd_addr];
            r_rd_val  <= mem_val[n_rd_addr];
        end
    end

    // Item capture and probe sequence
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_in) begin
            r_op     <= i_opcode;
            r_key    <= i_key[KW-1:0] & {KW{KEY_BITS > 0}};
            r_marked <= i_key_hash | 64'hC000_0000_0000_0000;
            r_val    <= i_value_in[VW-1:0] & {VW{VALUE_BITS > 0}};
            r_idx    <= i_key_hash[IW-1:0];
            r_step   <= '0;
            r_count  <= '0;
        end else if (i_cmd.step_probe) begin
            r_idx   <= r_idx + r_step + IW'(1);
            r_step  <= r_step + IW'(1);
            r_count <= r_count + (IW+1)'(1);
        end
    end

    // Counters, scan state and clearing sweep
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_live     <= '0;
            r_used     <= '0;
            r_scan_pos <= '0;
            r_scan_act <= 1'b0;
            r_sweep    <= '0;
        end else begin
            if (i_cmd.clr_sweep) r_sweep <= r_sweep + IW'(1);
            if (i_cmd.live_inc) begin
                r_live <= r_live + 11'd1;
                r_used <= r_used + (IW+1)'(1);
            end else if (i_cmd.live_dec) begin
                r_live <= r_live - 11'd1;
            end
            if (i_cmd.scan_start) begin
                r_scan_pos <= '0;
                r_scan_act <= 1'b1;
            end else if (i_cmd.scan_stop) begin
                r_scan_act <= 1'b0;
            end else if (i_cmd.scan_adv) begin
                r_scan_pos <= r_scan_pos + (IW+1)'(1);
            end
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_hit          <= 1'b0;
            o_status       <= oaht_pkg::ST_OK;
            o_key_out      <= '0;
            o_value_out    <= '0;
        end else if (i_cmd.res_load) begin
            o_hit       <= i_cmd.res_hit;
            o_status    <= i_cmd.res_status;
            o_key_out   <= i_cmd.res_data ? 64'(r_rd_key) : 64'd0;
            o_value_out <= (i_cmd.res_data || i_cmd.res_vonly) ? 64'(r_rd_val) : 64'd0;
        end
    end
    assign o_live_entries = r_live;

    // Status back to the controller
    always_comb begin
        o_stat.op          = r_op;
        o_stat.empty       = !r_rd_mark[oaht_pkg::MARK_VALID];
        o_stat.match       = (r_rd_mark == r_marked) && (r_rd_key == r_key);
        o_stat.live        = r_rd_mark[oaht_pkg::MARK_VALID] &&
                             r_rd_mark[oaht_pkg::MARK_VISIBLE];
        o_stat.probe_last  = (r_count == (IW+1)'(BUCKET_COUNT - 1));
        o_stat.room        = ((IW+1 > 10 ? r_used : (IW+1)'(r_used)) <
                              (IW+1)'(BUCKET_COUNT - 1)) &&
                             (32'(r_used) < 32'(i_load_limit));
        o_stat.scan_active = r_scan_act;
        o_stat.scan_end    = r_scan_pos[IW];
        o_stat.sweep_last  = (r_sweep == IW'(BUCKET_COUNT - 1));
        o_stat.live_pos    = (r_live != 11'd0);
    end

    `ASSERT_IMPL(a_live_le_used, i_clk, i_rst_n, 1'b1, 32'(r_live) <= 32'(r_used), "live count above used count")
    `ASSERT_NEXT(a_scan_pos_bound, i_clk, i_rst_n, i_cmd.scan_start, r_scan_pos == '0, "scan restart did not clear position")
    `ASSERT_IMPL(a_one_write, i_clk, i_rst_n, i_cmd.clr_sweep, !i_cmd.wr_new && !i_cmd.wr_val && !i_cmd.wr_tomb, "sweep collides with table write")
endmodule

>>> rtl/oaht_ctrl.sv
// Controller state machine for the hash table: sequences probes, scans and writes.
// Depends on oaht_pkg.
`include "assert_macros.svh"
module oaht_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    output logic            o_valid,
    input  logic            i_stall,
    input  oaht_pkg::t_stat i_stat,
    output oaht_pkg::t_cmd  o_cmd
);
    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_PRD, S_PCHK, S_SRD, S_SCHK, S_OUT
    } t_state;

    t_state r_state, n_state;
    logic   r_valid, n_valid;

    assign o_valid = r_valid;
    // Input taken only when idle and result slot free
    assign o_stall = !((r_state == S_IDLE) && !r_valid);

    always_comb begin
        n_state = r_state;
        n_valid = r_valid;
        o_cmd   = '0;
        if (r_valid && !i_stall) n_valid = 1'b0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr_sweep = 1'b1;
                if (i_stat.sweep_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_valid && !o_stall) begin
                    o_cmd.latch_in = 1'b1;
                    n_state = S_PRD;
                end
            end
            S_PRD: begin
                case (i_stat.op)
                    oaht_pkg::OP_FIND, oaht_pkg::OP_ADD, oaht_pkg::OP_DELETE: begin
                        o_cmd.rd_probe = 1'b1;
                        n_state = S_PCHK;
                    end
                    oaht_pkg::OP_SCAN_RST: begin
                        o_cmd.scan_start = 1'b1;
                        o_cmd.res_load   = 1'b1;
                        n_valid = 1'b1;
                        n_state = S_IDLE;
                    end
                    oaht_pkg::OP_SCAN_NEXT: begin
                        n_state = S_SRD;
                    end
                    default: begin
                        o_cmd.res_load = 1'b1;
                        n_valid = 1'b1;
                        n_state = S_IDLE;
                    end
                endcase
            end
            S_PCHK: begin
                if (i_stat.empty || i_stat.match) begin
                    o_cmd.res_load = 1'b1;
                    n_valid = 1'b1;
                    n_state = S_IDLE;
                    case (i_stat.op)
                        oaht_pkg::OP_FIND: begin
                            o_cmd.res_hit   = i_stat.match;
                            o_cmd.res_vonly = i_stat.match;
                        end
                        oaht_pkg::OP_ADD: begin
                            if (i_stat.match) begin
                                o_cmd.wr_val = 1'b1;
                            end else if (i_stat.room) begin
                                o_cmd.wr_new   = 1'b1;
                                o_cmd.live_inc = 1'b1;
                            end else begin
                                o_cmd.res_status = oaht_pkg::ST_REFUSED;
                            end
                        end
                        default: begin
                            if (i_stat.match) begin
                                o_cmd.wr_tomb  = 1'b1;
                                o_cmd.live_dec = i_stat.live_pos;
                                o_cmd.res_hit  = 1'b1;
                            end
                        end
                    endcase
                end else if (i_stat.probe_last) begin
                    o_cmd.res_load = 1'b1;
                    n_valid = 1'b1;
                    n_state = S_IDLE;
                    if (i_stat.op == oaht_pkg::OP_ADD) o_cmd.res_status = oaht_pkg::ST_REFUSED;
                end else begin
                    o_cmd.step_probe = 1'b1;
                    n_state = S_PRD;
                end
            end
            S_SRD: begin
                if (!i_stat.scan_active || i_stat.scan_end) begin
                    o_cmd.scan_stop  = i_stat.scan_active;
                    o_cmd.res_load   = 1'b1;
                    o_cmd.res_status = oaht_pkg::ST_SCANEND;
                    n_valid = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    o_cmd.rd_scan  = 1'b1;
                    o_cmd.scan_adv = 1'b1;
                    n_state = S_SCHK;
                end
            end
            S_SCHK: begin
                if (i_stat.live) begin
                    o_cmd.res_load = 1'b1;
                    o_cmd.res_hit  = 1'b1;
                    o_cmd.res_data = 1'b1;
                    n_valid = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_state = S_SRD;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

    `ASSERT_IMPL(a_load_free, i_clk, i_rst_n, o_cmd.res_load, !r_valid || !i_stall, "result overwritten while held")
    `ASSERT_IMPL(a_no_take_busy, i_clk, i_rst_n, o_cmd.latch_in, r_state == S_IDLE && !r_valid, "item taken while busy")
    `ASSERT_NEXT(a_clear_first, i_clk, i_rst_n, r_state == S_CLEAR, !r_valid, "result during clearing sweep")
endmodule
